@@ rtl/assert_macros.svh @@
// Assertion macros used by the receiver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/wsfr_pkg.sv @@
// Shared types and constants of the WebSocket frame receiver.
package wsfr_pkg;

    // Result kinds carried on the output tuser
    localparam logic [1:0] KIND_APP = 2'd0;
    localparam logic [1:0] KIND_TX  = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    // End codes carried in the value of a kind END result
    localparam logic [7:0] END_CLOSED   = 8'd0;
    localparam logic [7:0] END_BAD_OP   = 8'd1;
    localparam logic [7:0] END_UNMASKED = 8'd2;

    // Frame opcodes
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'hA;

    // Header bytes transmitted back to the client
    localparam logic [7:0] HDR_CLOSE = 8'h88;
    localparam logic [7:0] HDR_PONG  = 8'h8A;
    localparam logic [7:0] LEN_ZERO  = 8'h00;

    // Length byte codes
    localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN7_EXT16     = 7'd126;
    localparam logic [7:0] LEN_CODE16     = 8'd126;
    localparam logic [7:0] LEN_CODE64     = 8'd127;
    localparam logic [63:0] LEN_MAX_SHORT = 64'd125;
    localparam logic [63:0] LEN_MAX_16    = 64'd65535;

    // Commands passed from the parser to the result sequencer
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_PONG  = 2'd2;

    // Pong length formats
    localparam logic [1:0] FMT_SHORT = 2'd0;
    localparam logic [1:0] FMT_16    = 2'd1;
    localparam logic [1:0] FMT_64    = 2'd2;

    // Index of the final beat of each multi-beat command, and of the first length beat
    localparam logic [3:0] LAST_IDX_CLOSE = 4'd2;
    localparam logic [3:0] LAST_IDX_SHORT = 4'd1;
    localparam logic [3:0] LAST_IDX_16    = 4'd3;
    localparam logic [3:0] LAST_IDX_64    = 4'd9;
    localparam logic [3:0] FIRST_LEN_IDX  = 4'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [1:0]  fmt;
        logic [63:0] len;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ rtl/wsfr_frame_parser.sv @@
// Front end: accepts client bytes, parses frame headers and unmasks payload.
module wsfr_frame_parser
    import wsfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  q_status_t  q_status,
    output push_t      push
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_STOPPED = 3'd5;

    localparam logic [1:0] FK_DATA = 2'd0;
    localparam logic [1:0] FK_PING = 2'd1;
    localparam logic [1:0] FK_PONG = 2'd2;

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  fkind_reg, fkind_next;
    logic [3:0]  opc_reg, opc_next;
    logic [63:0] rem_reg, rem_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  mpos_reg, mpos_next;

    logic        in_fire;
    logic [7:0]  key_byte;
    logic [6:0]  len7;

    assign s_tready = !q_status.full;
    assign in_fire  = s_tvalid && s_tready;
    assign len7     = s_tdata[6:0];

    // Select the mask byte for the current payload position
    always_comb
    begin
        case (mpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Advance the parse state and issue commands
    always_comb
    begin
        phase_next     = phase_reg;
        fkind_next     = fkind_reg;
        opc_next       = opc_reg;
        rem_next       = rem_reg;
        fcnt_next      = fcnt_reg;
        key_next       = key_reg;
        mpos_next      = mpos_reg;
        push.valid     = 1'b0;
        push.cmd.op    = OP_BYTE;
        push.cmd.kind  = KIND_APP;
        push.cmd.value = 8'h00;
        push.cmd.fmt   = FMT_SHORT;
        push.cmd.len   = rem_reg;
        if (in_fire)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    opc_next   = s_tdata[3:0];
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (opc_reg == OPC_CLOSE)
                    begin
                        push.valid  = 1'b1;
                        push.cmd.op = OP_CLOSE;
                        phase_next  = PH_STOPPED;
                    end
                    else if (!(opc_reg inside {[4'h0:OPC_BINARY], OPC_PING, OPC_PONG}))
                    begin
                        push.valid     = 1'b1;
                        push.cmd.kind  = KIND_END;
                        push.cmd.value = END_BAD_OP;
                        phase_next     = PH_STOPPED;
                    end
                    else if (!s_tdata[7])
                    begin
                        push.valid     = 1'b1;
                        push.cmd.kind  = KIND_END;
                        push.cmd.value = END_UNMASKED;
                        phase_next     = PH_STOPPED;
                    end
                    else
                    begin
                        if (opc_reg == OPC_PING)
                        begin
                            fkind_next = FK_PING;
                        end
                        else if (opc_reg == OPC_PONG)
                        begin
                            fkind_next = FK_PONG;
                        end
                        else
                        begin
                            fkind_next = FK_DATA;
                        end
                        if (len7 <= LEN7_MAX_SHORT)
                        begin
                            rem_next   = {57'd0, len7};
                            fcnt_next  = 4'd4;
                            phase_next = PH_MASK;
                        end
                        else
                        begin
                            rem_next   = 64'd0;
                            fcnt_next  = (len7 == LEN7_EXT16) ? 4'd2 : 4'd8;
                            phase_next = PH_EXTLEN;
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    rem_next  = {rem_reg[55:0], s_tdata};
                    fcnt_next = fcnt_reg - 4'd1;
                    if (fcnt_reg == 4'd1)
                    begin
                        fcnt_next  = 4'd4;
                        phase_next = PH_MASK;
                    end
                end
                PH_MASK:
                begin
                    key_next  = {key_reg[23:0], s_tdata};
                    fcnt_next = fcnt_reg - 4'd1;
                    if (fcnt_reg == 4'd1)
                    begin
                        mpos_next = 2'd0;
                        // Queue the pong header for a ping
                        if (fkind_reg == FK_PING)
                        begin
                            push.valid  = 1'b1;
                            push.cmd.op = OP_PONG;
                            if (rem_reg <= LEN_MAX_SHORT)
                            begin
                                push.cmd.fmt   = FMT_SHORT;
                                push.cmd.value = rem_reg[7:0];
                            end
                            else if (rem_reg <= LEN_MAX_16)
                            begin
                                push.cmd.fmt   = FMT_16;
                                push.cmd.value = LEN_CODE16;
                            end
                            else
                            begin
                                push.cmd.fmt   = FMT_64;
                                push.cmd.value = LEN_CODE64;
                            end
                        end
                        phase_next = (rem_reg == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    mpos_next      = mpos_reg + 2'd1;
                    push.cmd.value = s_tdata ^ key_byte;
                    if (fkind_reg == FK_DATA)
                    begin
                        push.valid    = 1'b1;
                        push.cmd.kind = KIND_APP;
                    end
                    else if (fkind_reg == FK_PING)
                    begin
                        push.valid    = 1'b1;
                        push.cmd.kind = KIND_TX;
                    end
                    rem_next = rem_reg - 64'd1;
                    if (rem_reg == 64'd1)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    // Stopped: drop every byte
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            fkind_reg <= FK_DATA;
            opc_reg   <= 4'd0;
            rem_reg   <= 64'd0;
            fcnt_reg  <= 4'd0;
            key_reg   <= 32'd0;
            mpos_reg  <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            fkind_reg <= fkind_next;
            opc_reg   <= opc_next;
            rem_reg   <= rem_next;
            fcnt_reg  <= fcnt_next;
            key_reg   <= key_next;
            mpos_reg  <= mpos_next;
        end
    end

endmodule

@@ rtl/wsfr_cmd_queue.sv @@
// Short command queue between the parser and the result sequencer.
module wsfr_cmd_queue
    import wsfr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push.valid && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_ONE;
            2'b01:   count_next = count_reg - CNT_ONE;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

@@ rtl/wsfr_result_seq.sv @@
// Back end: expands queued commands into result beats.
module wsfr_result_seq
    import wsfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] value
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast
);

    logic        cur_valid_reg, cur_valid_next;
    cmd_t        cur_reg, cur_next;
    logic [3:0]  idx_reg, idx_next;
    logic [63:0] sh_reg, sh_next;
    logic        m_fire, last_beat, load;
    logic [3:0]  pong_last;

    assign m_fire   = cur_valid_reg && m_tready;
    assign m_tvalid = cur_valid_reg;
    assign m_tlast  = last_beat;

    // Pick the final beat index of a pong header
    always_comb
    begin
        case (cur_reg.fmt)
            FMT_SHORT: pong_last = LAST_IDX_SHORT;
            FMT_16:    pong_last = LAST_IDX_16;
            default:   pong_last = LAST_IDX_64;
        endcase
    end

    // Form the current beat
    always_comb
    begin
        m_tuser   = KIND_TX;
        m_tdata   = cur_reg.value;
        last_beat = 1'b1;
        case (cur_reg.op)
            OP_CLOSE:
            begin
                last_beat = (idx_reg == LAST_IDX_CLOSE);
                if (idx_reg == 4'd0)
                begin
                    m_tdata = HDR_CLOSE;
                end
                else if (idx_reg == 4'd1)
                begin
                    m_tdata = LEN_ZERO;
                end
                else
                begin
                    m_tuser = KIND_END;
                    m_tdata = END_CLOSED;
                end
            end
            OP_PONG:
            begin
                last_beat = (idx_reg == pong_last);
                if (idx_reg == 4'd0)
                begin
                    m_tdata = HDR_PONG;
                end
                else if (idx_reg >= FIRST_LEN_IDX)
                begin
                    m_tdata = sh_reg[63:56];
                end
            end
            default:
            begin
                m_tuser = cur_reg.kind;
            end
        endcase
    end

    assign load = !cur_valid_reg || (m_fire && last_beat);
    assign pop  = load && !q_status.empty;

    // Load the next command or step through the current one
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        sh_next        = sh_reg;
        if (load)
        begin
            cur_valid_next = !q_status.empty;
            cur_next       = head;
            idx_next       = 4'd0;
            sh_next        = (head.fmt == FMT_16) ? {head.len[15:0], 48'd0} : head.len;
        end
        else if (m_fire)
        begin
            idx_next = idx_reg + 4'd1;
            if (idx_reg >= FIRST_LEN_IDX)
            begin
                sh_next = {sh_reg[55:0], 8'd0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Hold the command payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        sh_reg  <= sh_next;
    end

endmodule

@@ rtl/websocket_server_frame_receiver.sv @@
// A result beat is registered: its command passes through the command queue, then the sequencer's command register.
// Throughput: one byte per cycle; the parser stalls only when the command queue fills.
// A close answer takes 3 output beats and a pong header 2, 4 or 10 beats from the sequencer.
// Reset: rst_n is asynchronous, active low; the parser expects a first header byte.
// After a stop result every further byte is accepted and dropped until reset.
`include "assert_macros.svh"

module websocket_server_frame_receiver
    import wsfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] value
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast
);

    push_t     push;
    q_status_t q_status;
    cmd_t      head;
    logic      pop;

    // Parse incoming bytes
    wsfr_frame_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push)
    );

    // Buffer commands between the two sides
    wsfr_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    // Expand commands into result beats
    wsfr_result_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `ASSERT_NEVER(a_push_when_full, clk, rst_n, push.valid && q_status.full, "push into full queue")
    `ASSERT_CLK(a_full_has_output, clk, rst_n, q_status.full |-> m_tvalid, "full queue, idle output")
    `ASSERT_CLK(a_app_single_beat, clk, rst_n, (m_tvalid && m_tuser == KIND_APP) |-> m_tlast, "app beat not last")
    `ASSERT_CLK(a_end_is_final, clk, rst_n, (m_tvalid && m_tready && m_tuser == KIND_END) |=> !m_tvalid, "beat after end")

endmodule
